FILE: hdl/iot_pkg.sv
// iot_pkg: shared types and constants of the interval overlay table
// segment record, controller command and datapath status structs
// no dependencies
package iot_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int TIME_W          = 31;
    localparam int TAG_W           = 32;

    // one stored segment
    typedef struct packed {
        logic [TIME_W-1:0] seg_start;
        logic [TIME_W-1:0] seg_end;
        logic [TAG_W-1:0]  seg_tag;
    } t_seg;

    // commands from the controller to the datapath
    typedef struct packed {
        logic start;       // latch the new segment, clear walk counters
        logic rd_entry;    // read stored entry at the walk index
        logic eval;        // classify the entry just read
        logic push;        // write one pending piece to the work bank
        logic next;        // step the walk index
        logic push_final;  // place the new segment at the end if still unplaced
        logic commit;      // swap banks and take the new count
        logic emit_rd;     // read the entry to emit
        logic emit_ld;     // load the read entry into the output register
        logic ovf_ld;      // load an overflow beat into the output register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic walk_done;   // every stored entry has been visited
        logic over;        // result would exceed the table depth
        logic pend_any;    // pieces of the current entry still to write
        logic slot_free;   // output register can take a beat
        logic emit_last;   // entry being emitted is the final one
    } t_stat;

endpackage

FILE: hdl/iot_if.sv
// iot_if: valid/ready channel interfaces of the interval overlay table
// input channel carries a new segment, output channel one table entry per beat
// depends on iot_pkg
interface iot_in_if;
    import iot_pkg::*;

    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] new_start;
    logic [TIME_W-1:0] new_end;
    logic [TAG_W-1:0]  new_tag;

    modport source (output valid, output new_start, output new_end, output new_tag,
                    input ready);
    modport sink   (input valid, input new_start, input new_end, input new_tag,
                    output ready);
endinterface

interface iot_out_if;
    import iot_pkg::*;

    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] entry_start;
    logic [TIME_W-1:0] entry_end;
    logic [TAG_W-1:0]  entry_tag;
    logic              last_entry;
    logic              status;

    modport source (output valid, output entry_start, output entry_end, output entry_tag,
                    output last_entry, output status, input ready);
    modport sink   (input valid, input entry_start, input entry_end, input entry_tag,
                    input last_entry, input status, output ready);
endinterface

FILE: hdl/iot_ctrl.sv
// iot_ctrl: controller state machine of the interval overlay table
// sequences the walk, the commit and the emission through command/status structs
// depends on iot_pkg
module iot_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  iot_pkg::t_stat i_stat,
    output iot_pkg::t_cmd  o_cmd
);
    import iot_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_EVAL,
        S_PUSH,
        S_FINAL,
        S_DECIDE,
        S_EMIT_RD,
        S_EMIT_LD,
        S_OVF
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.over) begin
                    n_state = S_DECIDE;
                end else if (i_stat.walk_done) begin
                    n_state = S_FINAL;
                end else begin
                    o_cmd.rd_entry = 1'b1;
                    n_state        = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_PUSH;
            end
            S_PUSH: begin
                if (i_stat.pend_any && !i_stat.over) begin
                    o_cmd.push = 1'b1;
                end else begin
                    o_cmd.next = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_FINAL: begin
                o_cmd.push_final = 1'b1;
                n_state          = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.over) begin
                    n_state = S_OVF;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit_ld = 1'b1;
                    n_state       = i_stat.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            S_OVF: begin
                if (i_stat.slot_free) begin
                    o_cmd.ovf_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hdl/iot_datapath.sv
// iot_datapath: two-bank segment memory, walk counters, overlap classifier
// and output register of the interval overlay table
// depends on iot_pkg
module iot_datapath #(
    parameter int TABLE_DEPTH = iot_pkg::TABLE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  iot_pkg::t_cmd             i_cmd,
    output iot_pkg::t_stat            o_stat,
    input  logic [iot_pkg::TIME_W-1:0] i_new_start,
    input  logic [iot_pkg::TIME_W-1:0] i_new_end,
    input  logic [iot_pkg::TAG_W-1:0]  i_new_tag,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [iot_pkg::TIME_W-1:0] o_entry_start,
    output logic [iot_pkg::TIME_W-1:0] o_entry_end,
    output logic [iot_pkg::TAG_W-1:0]  o_entry_tag,
    output logic                      o_last_entry,
    output logic                      o_status
);
    import iot_pkg::*;

    localparam int IW    = $clog2(TABLE_DEPTH);
    localparam int AW    = IW + 1;
    localparam int MEM_D = 2 ** AW;
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int NW    = $clog2(TABLE_DEPTH + 2);

    // both banks share one memory, the bank bit selects the upper half
    t_seg r_mem [MEM_D];
    t_seg r_rd;

    logic [TIME_W-1:0] r_ns;
    logic [TIME_W-1:0] r_ne;
    logic [TAG_W-1:0]  r_nt;

    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_k;
    logic [NW-1:0] r_n;
    logic          r_bank;
    logic          r_placed;
    logic          r_pend_a;
    logic          r_pend_b;
    logic          r_pend_c;
    logic          r_kind_before;
    logic          r_kind_after;

    t_seg r_out;
    logic r_out_valid;
    logic r_out_last;
    logic r_out_status;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          use_new;
    logic          push_fire;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_seg          wr_data;
    t_seg          new_seg;
    logic          cls_covered;
    logic          cls_before;
    logic          cls_after;
    logic          cls_partial;
    logic          room;
    logic          pend_any;

    assign new_seg  = '{seg_start: r_ns, seg_end: r_ne, seg_tag: r_nt};
    assign pend_any = r_pend_a | r_pend_b | r_pend_c;
    assign room     = r_n < NW'(TABLE_DEPTH);

    // overlap classes of the stored entry against the new segment
    always_comb begin
        cls_covered = (r_ns <= r_rd.seg_start) && (r_ne >= r_rd.seg_end);
        cls_before  = !cls_covered && (r_rd.seg_end <= r_ns);
        cls_after   = !cls_covered && !cls_before && (r_rd.seg_start >= r_ne);
        cls_partial = !cls_covered && !cls_before && !cls_after;
    end

    // piece selection, in order left piece, new segment, right piece
    always_comb begin
        use_new   = i_cmd.push_final || (!r_pend_a && r_pend_b);
        push_fire = (i_cmd.push && pend_any) || (i_cmd.push_final && !r_placed);
        if (use_new) begin
            wr_data = new_seg;
        end else if (r_pend_a) begin
            wr_data = r_kind_before ? r_rd
                    : t_seg'{seg_start: r_rd.seg_start, seg_end: r_ns, seg_tag: r_rd.seg_tag};
        end else begin
            wr_data = r_kind_after ? r_rd
                    : t_seg'{seg_start: r_ne, seg_end: r_rd.seg_end, seg_tag: r_rd.seg_tag};
        end
        wr_en   = push_fire && room;
        wr_addr = {~r_bank, r_n[IW-1:0]};
    end

    // read port serves the walk and the emission
    always_comb begin
        rd_en   = i_cmd.rd_entry | i_cmd.emit_rd;
        rd_addr = i_cmd.emit_rd ? {r_bank, r_k[IW-1:0]} : {r_bank, r_idx[IW-1:0]};
    end

    // segment memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // new segment capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ns <= i_new_start;
            r_ne <= i_new_end;
            r_nt <= i_new_tag;
        end
    end

    // walk and table control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx         <= '0;
            r_count       <= '0;
            r_k           <= '0;
            r_n           <= '0;
            r_bank        <= 1'b0;
            r_placed      <= 1'b0;
            r_pend_a      <= 1'b0;
            r_pend_b      <= 1'b0;
            r_pend_c      <= 1'b0;
            r_kind_before <= 1'b0;
            r_kind_after  <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_idx    <= '0;
                r_n      <= '0;
                r_placed <= 1'b0;
                r_pend_a <= 1'b0;
                r_pend_b <= 1'b0;
                r_pend_c <= 1'b0;
            end
            if (i_cmd.eval) begin
                r_kind_before <= cls_before;
                r_kind_after  <= cls_after;
                r_pend_a      <= cls_before || (cls_partial && (r_rd.seg_start < r_ns));
                r_pend_b      <= !r_placed && (cls_after || cls_partial);
                r_pend_c      <= cls_after || (cls_partial && (r_rd.seg_end > r_ne));
            end
            if (push_fire) begin
                // count keeps going past the depth only far enough to flag overflow
                if (r_n <= NW'(TABLE_DEPTH)) begin
                    r_n <= r_n + NW'(1);
                end
                if (use_new) begin
                    r_placed <= 1'b1;
                    if (!i_cmd.push_final) begin
                        r_pend_b <= 1'b0;
                    end
                end else if (r_pend_a) begin
                    r_pend_a <= 1'b0;
                end else begin
                    r_pend_c <= 1'b0;
                end
            end
            if (i_cmd.next) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.commit) begin
                r_bank  <= ~r_bank;
                r_count <= CW'(r_n);
                r_k     <= '0;
            end
            if (i_cmd.emit_ld) begin
                r_k <= r_k + CW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_ld || i_cmd.ovf_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_ld) begin
            r_out        <= r_rd;
            r_out_last   <= o_stat.emit_last;
            r_out_status <= 1'b0;
        end else if (i_cmd.ovf_ld) begin
            r_out        <= '0;
            r_out_last   <= 1'b1;
            r_out_status <= 1'b1;
        end
    end

    // status to the controller
    always_comb begin
        o_stat.walk_done = (r_idx == r_count);
        o_stat.over      = r_n > NW'(TABLE_DEPTH);
        o_stat.pend_any  = pend_any;
        o_stat.slot_free = !r_out_valid || i_out_ready;
        o_stat.emit_last = (CW'(r_k + CW'(1)) == r_count);
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_start = r_out.seg_start;
    assign o_entry_end   = r_out.seg_end;
    assign o_entry_tag   = r_out.seg_tag;
    assign o_last_entry  = r_out_last;
    assign o_status      = r_out_status;

endmodule

FILE: hdl/interval_overlay_table_top.sv
// interval_overlay_table_top: each insert walks the stored entries (read, classify,
// write pieces), places the new segment, then commits and emits all entries, stalling on
// back-pressure, or on overflow sends one status beat; a new insert is taken only in idle,
// as walk, rewrite and emission share the single read and single write memory port.
// reset empties the table (count zero) with no clearing pass; memory contents are not reset
// depends on iot_pkg, iot_if, iot_ctrl, iot_datapath
module interval_overlay_table_top #(
    parameter int TABLE_DEPTH = iot_pkg::TABLE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iot_in_if.sink    i_in,
    iot_out_if.source o_out
);
    import iot_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    // controller
    iot_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath
    iot_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_new_start   (i_in.new_start),
        .i_new_end     (i_in.new_end),
        .i_new_tag     (i_in.new_tag),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_entry_start (o_out.entry_start),
        .o_entry_end   (o_out.entry_end),
        .o_entry_tag   (o_out.entry_tag),
        .o_last_entry  (o_out.last_entry),
        .o_status      (o_out.status)
    );

    assign i_in.ready = in_ready;

    // a rejected insert never reaches the table
    a_commit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !stat.over)
        else $error("commit with overflowing result");

    // an overflow beat is a single zeroed final beat
    a_ovf_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status) |->
            (o_out.last_entry && (o_out.entry_start == '0) && (o_out.entry_end == '0)
             && (o_out.entry_tag == '0)))
        else $error("malformed overflow beat");

    // one insert at a time
    a_one_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken during an insert");

endmodule
